### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/ppgq_pkg.sv
package ppgq_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 2;

  // Suspect captures kept before the stored maximum is installed
  localparam logic [CountW-1:0] SUSPECT_LIMIT = 2'd3;

  // Register indexes on the configuration port
  localparam logic CFG_MIN_PERIOD   = 1'b0;
  localparam logic CFG_START_PERIOD = 1'b1;

  // Item kinds
  localparam logic MODE_CAPTURE  = 1'b0;
  localparam logic MODE_OVERFLOW = 1'b1;

  localparam logic [PeriodW-1:0] MIN_PERIOD_RST   = 16'h0000;
  localparam logic [PeriodW-1:0] START_PERIOD_RST = 16'hFFFF;

  typedef struct packed {
    logic [PeriodW-1:0] min_period;
    logic [PeriodW-1:0] start_period;
  } cfg_t;

  typedef struct packed {
    logic               armed;
    logic [PeriodW-1:0] accepted;
    logic [PeriodW-1:0] suspect_max;
    logic [CountW-1:0]  suspect_count;
  } qual_state_t;

endpackage

### rtl/ppgq_cfg_regs.sv
module ppgq_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_idx_i,
  input  logic [ppgq_pkg::PeriodW-1:0]   cfg_data_i,
  output ppgq_pkg::cfg_t                 cfg_o
);

  ppgq_pkg::cfg_t cfg_q;

  // The port accepts every write, so it never stalls
  assign cfg_ready_o = 1'b1;

  // Decode the register index and store the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_period   <= ppgq_pkg::MIN_PERIOD_RST;
      cfg_q.start_period <= ppgq_pkg::START_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        ppgq_pkg::CFG_MIN_PERIOD:   cfg_q.min_period   <= cfg_data_i;
        ppgq_pkg::CFG_START_PERIOD: cfg_q.start_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ppgq_core.sv
module ppgq_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           mode_i,
  input  logic [ppgq_pkg::PeriodW-1:0]   captured_i,
  input  ppgq_pkg::cfg_t                 cfg_i,
  output ppgq_pkg::qual_state_t          state_d_o
);

  ppgq_pkg::qual_state_t st_q, st_d;
  logic [ppgq_pkg::PeriodW-1:0] drop;
  logic [ppgq_pkg::PeriodW-1:0] half;

  assign drop = st_q.accepted - captured_i;
  assign half = {1'b0, st_q.accepted[ppgq_pkg::PeriodW-1:1]};

  // Qualify one capture with suspect tracking; an overflow disarms
  always_comb begin
    st_d = st_q;
    if (mode_i == ppgq_pkg::MODE_OVERFLOW) begin
      st_d.accepted = '0;
      st_d.armed    = 1'b0;
    end else if (!st_q.armed) begin
      st_d.accepted      = cfg_i.start_period;
      st_d.armed         = 1'b1;
      st_d.suspect_max   = '0;
      st_d.suspect_count = '0;
    end else if (captured_i <= cfg_i.min_period) begin
      // Glitch: keep the period, drop the suspects
      st_d.suspect_max   = '0;
      st_d.suspect_count = '0;
    end else if (captured_i < st_q.accepted && drop >= half) begin
      // Sharp drop
      if (st_q.suspect_count < ppgq_pkg::SUSPECT_LIMIT) begin
        if (captured_i > st_q.suspect_max) begin
          st_d.suspect_max = captured_i;
        end
        st_d.suspect_count = st_q.suspect_count + 1'b1;
      end else begin
        st_d.accepted      = st_q.suspect_max;
        st_d.suspect_max   = '0;
        st_d.suspect_count = '0;
      end
    end else begin
      // Mild drop or no drop: accept the capture
      st_d.accepted      = captured_i;
      st_d.suspect_max   = '0;
      st_d.suspect_count = '0;
    end
  end

  // Advance the state once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign state_d_o = st_d;

endmodule

### rtl/pulse_period_glitch_qualifier.sv
// Channel | Handshake             | Beat contents
// in      | in_valid_i/in_ready_o | mode_i, captured_i
// out     | out_valid_o/out_ready_i | period_o, armed_o
// cfg     | cfg_valid_i/cfg_ready_o | cfg_idx_i, cfg_data_i
//
// Each item passes through the input register and then the result register on its
// way from input beat to result beat. One item per cycle is sustained while results
// are taken, with the qualify update between the two registers.
// Reset clears the state, the valid flags and loads the register defaults.
// A held result stalls the input register, and then the input channel.
module pulse_period_glitch_qualifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [ppgq_pkg::PeriodW-1:0]   captured_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ppgq_pkg::PeriodW-1:0]   period_o,
  output logic                           armed_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_idx_i,
  input  logic [ppgq_pkg::PeriodW-1:0]   cfg_data_i
);

  ppgq_pkg::cfg_t        cfg;
  ppgq_pkg::qual_state_t st_d;

  logic                         in_vld_q;
  logic                         mode_q;
  logic [ppgq_pkg::PeriodW-1:0] cap_q;
  logic                         out_vld_q;
  logic [ppgq_pkg::PeriodW-1:0] period_q;
  logic                         armed_q;
  logic                         advance;

  ppgq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move an item to the result register when that register is free or its beat is being taken
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  ppgq_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .mode_i     (mode_q),
    .captured_i (cap_q),
    .cfg_i      (cfg),
    .state_d_o  (st_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the input beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      cap_q  <= captured_i;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (advance) begin
      period_q <= st_d.accepted;
      armed_q  <= st_d.armed;
    end
  end

  assign out_valid_o = out_vld_q;
  assign period_o    = period_q;
  assign armed_o     = armed_q;

endmodule

### rtl/ppgq_checker.sv
`include "assert_macros.svh"

module ppgq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ppgq_pkg::PeriodW-1:0]   period_o,
  input logic                           armed_o
);

  // A held result beat keeps its payload
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(period_o) && $stable(armed_o))

  // An unarmed result always reports a stopped period
  `ASSERT_IMPLY(a_unarmed_zero, clk_i, rst_ni, out_valid_o && !armed_o, period_o == '0)

  // Input stalls only behind a held result
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // A fresh result follows an accepted input beat
  `ASSERT_IMPLY(a_no_invent, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))

endmodule

bind pulse_period_glitch_qualifier ppgq_checker u_ppgq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .period_o    (period_o),
  .armed_o     (armed_o)
);
